>>> hdl/ippa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippa_pkg
// Types, codes and helpers shared by the interrupt priority arbiter modules.
// ----------------------------------------------------------------------------
package ippa_pkg;

	localparam int NUM_IRQ_DEF = 16;
	localparam int EN_W        = 16;

	// command codes
	localparam logic [2:0] CMD_SET_PEND   = 3'd0;
	localparam logic [2:0] CMD_CHECK      = 3'd1;
	localparam logic [2:0] CMD_WR_PRIO    = 3'd2;
	localparam logic [2:0] CMD_HARD_FAULT = 3'd3;
	localparam logic [2:0] CMD_EXC_RETURN = 3'd4;

	// register indexes
	localparam logic [1:0] REG_IRQ_ENABLE = 2'd0;
	localparam logic [1:0] REG_SYS_PRIO_A = 2'd1;
	localparam logic [1:0] REG_SYS_PRIO_B = 2'd2;
	localparam logic [1:0] REG_REDUCED    = 2'd3;

	// exception numbers
	localparam logic [8:0] EXC_NONE       = 9'd0;
	localparam logic [8:0] EXC_HARD_FAULT = 9'd3;
	localparam logic [8:0] EXC_TICK       = 9'd15;
	localparam logic [8:0] EXC_IRQ_BASE   = 9'd16;

	localparam logic [8:0] PRIO_NONE      = 9'd256;
	localparam logic [8:0] PRIO_UNKNOWN   = 9'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TREE,
		ST_DECIDE
	} state_t;

	typedef struct packed {
		logic [15:0] irq_enable;
		logic [31:0] sys_prio_a;
		logic [31:0] sys_prio_b;
		logic        reduced;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic eval;
		logic commit;
	} dp_ctrl_t;

	function automatic logic [7:0] scale_prio(input logic [7:0] b, input logic reduced);
		return reduced ? {6'b0, b[7:6]} : b;
	endfunction

endpackage

>>> hdl/ippa_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippa_regs
// APB configuration registers: enable mask, system priorities, priority mode.
// ----------------------------------------------------------------------------
module ippa_regs
	import ippa_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_IRQ_ENABLE: cfg_q.irq_enable <= pwdata[15:0];
				REG_SYS_PRIO_A: cfg_q.sys_prio_a <= pwdata;
				REG_SYS_PRIO_B: cfg_q.sys_prio_b <= pwdata;
				REG_REDUCED:    cfg_q.reduced    <= pwdata[0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_IRQ_ENABLE: prdata = {16'b0, cfg_q.irq_enable};
			REG_SYS_PRIO_A: prdata = cfg_q.sys_prio_a;
			REG_SYS_PRIO_B: prdata = cfg_q.sys_prio_b;
			REG_REDUCED:    prdata = {31'b0, cfg_q.reduced};
			default:        prdata = '0;
		endcase
	end

endmodule

>>> hdl/ippa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippa_ctrl
// Sequencer: capture a command, run the priority tree, commit the result.
// ----------------------------------------------------------------------------
module ippa_ctrl
	import ippa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output dp_ctrl_t dp_ctrl
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dp_ctrl = '0;
		busy    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					dp_ctrl.load = 1'b1;
					state_d      = ST_TREE;
				end
			end
			ST_TREE: begin
				busy         = 1'b1;
				dp_ctrl.eval = 1'b1;
				state_d      = ST_DECIDE;
			end
			ST_DECIDE: begin
				// commit this transaction and take the next one in the same cycle
				dp_ctrl.commit = 1'b1;
				if (start) begin
					dp_ctrl.load = 1'b1;
					state_d      = ST_TREE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> hdl/ippa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ippa_dp
// Arbiter datapath: pending and priority state, two-level priority tree,
// preemption decision and result register.
// ----------------------------------------------------------------------------
module ippa_dp
	import ippa_pkg::*;
#(
	parameter int NUM_IRQ = NUM_IRQ_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_ctrl_t   dp_ctrl,
	input  cfg_t       cfg,
	input  logic [2:0] cmd,
	input  logic [8:0] exc_number,
	input  logic [3:0] irq_index,
	input  logic [7:0] priority_byte,
	input  logic       interrupts_masked,
	output logic       done,
	output logic       taken,
	output logic [8:0] taken_number,
	output logic       locked_up,
	output logic [8:0] active_number
);

	localparam int IDX_W  = (NUM_IRQ > 1) ? $clog2(NUM_IRQ) : 1;
	localparam int GRP    = (NUM_IRQ + 3) / 4;

	// captured command
	logic [2:0] cmd_q;
	logic [8:0] exc_q;
	logic [3:0] idx_q;
	logic [7:0] pb_q;
	logic       masked_q;

	// arbiter state; top pending bit is the tick source
	logic [NUM_IRQ:0]   pend_q;
	logic [7:0]         prio_q [NUM_IRQ];
	logic [8:0]         act_q;
	logic               lock_q;

	// tree stage
	logic               grp_vld_s1  [GRP];
	logic [7:0]         grp_prio_s1 [GRP];
	logic [IDX_W-1:0]   grp_idx_s1  [GRP];
	logic               grp_vld     [GRP];
	logic [7:0]         grp_prio    [GRP];
	logic [IDX_W-1:0]   grp_idx     [GRP];

	logic [NUM_IRQ+EN_W-1:0] en_ext;
	logic [NUM_IRQ-1:0]      cand;

	// decide stage
	logic               best_vld;
	logic [7:0]         best_level;
	logic [IDX_W-1:0]   best_idx;
	logic [7:0]         tick_prio;
	logic [8:0]         act_prio;
	logic               check_go;
	logic               tick_take;
	logic               irq_take;

	logic [NUM_IRQ:0]   pend_d;
	logic [8:0]         act_d;
	logic               lock_d;
	logic               taken_d;
	logic [8:0]         tnum_d;

	logic               done_q;
	logic               taken_q;
	logic [8:0]         tnum_q;

	assign en_ext = {{NUM_IRQ{1'b0}}, cfg.irq_enable};
	assign cand   = pend_q[NUM_IRQ-1:0] & en_ext[NUM_IRQ-1:0];

	always_ff @(posedge clk) begin
		if (dp_ctrl.load) begin
			cmd_q    <= cmd;
			exc_q    <= exc_number;
			idx_q    <= irq_index;
			pb_q     <= priority_byte;
			masked_q <= interrupts_masked;
		end
	end

	// first level: best enabled pending line in each group of four
	always_comb begin
		for (int g = 0; g < GRP; g++) begin
			grp_vld[g]  = 1'b0;
			grp_prio[g] = '0;
			grp_idx[g]  = '0;
			for (int k = 0; k < 4; k++) begin
				if (4 * g + k < NUM_IRQ) begin
					if (cand[4 * g + k] &&
						(!grp_vld[g] ||
						 scale_prio(prio_q[4 * g + k], cfg.reduced) < grp_prio[g])) begin
						grp_vld[g]  = 1'b1;
						grp_prio[g] = scale_prio(prio_q[4 * g + k], cfg.reduced);
						grp_idx[g]  = IDX_W'(4 * g + k);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.eval) begin
			for (int g = 0; g < GRP; g++) begin
				grp_vld_s1[g]  <= grp_vld[g];
				grp_prio_s1[g] <= grp_prio[g];
				grp_idx_s1[g]  <= grp_idx[g];
			end
		end
	end

	// second level: ascending scan with strict compare keeps the lowest index on a tie
	always_comb begin
		best_vld   = 1'b0;
		best_level = '0;
		best_idx   = '0;
		for (int g = 0; g < GRP; g++) begin
			if (grp_vld_s1[g] && (!best_vld || grp_prio_s1[g] < best_level)) begin
				best_vld   = 1'b1;
				best_level = grp_prio_s1[g];
				best_idx   = grp_idx_s1[g];
			end
		end
	end

	// priority of the active exception
	always_comb begin
		tick_prio = scale_prio(cfg.sys_prio_b[31:24], cfg.reduced);
		if (act_q == EXC_NONE) begin
			act_prio = PRIO_NONE;
		end else if (act_q[8:3] == 6'd0) begin
			act_prio = '0;
		end else if (act_q[8:2] == 7'd2) begin
			act_prio = {1'b0, scale_prio(cfg.sys_prio_a[{act_q[1:0], 3'b000} +: 8],
				cfg.reduced)};
		end else if (act_q[8:2] == 7'd3) begin
			act_prio = {1'b0, scale_prio(cfg.sys_prio_b[{act_q[1:0], 3'b000} +: 8],
				cfg.reduced)};
		end else begin
			act_prio = PRIO_UNKNOWN;
			for (int i = 0; i < NUM_IRQ; i++) begin
				if (act_q == EXC_IRQ_BASE + 9'(i)) begin
					act_prio = {1'b0, scale_prio(prio_q[i], cfg.reduced)};
				end
			end
		end
	end

	assign check_go  = (cmd_q == CMD_CHECK) && !masked_q && !lock_q;
	assign tick_take = pend_q[NUM_IRQ] &&
		((act_q == EXC_NONE) || ({1'b0, tick_prio} < act_prio));
	assign irq_take  = !tick_take && best_vld &&
		((act_q == EXC_NONE) || ({1'b0, best_level} < act_prio));

	always_comb begin
		pend_d  = pend_q;
		act_d   = act_q;
		lock_d  = lock_q;
		taken_d = 1'b0;
		tnum_d  = EXC_NONE;
		case (cmd_q)
			CMD_SET_PEND: begin
				if (exc_q == EXC_TICK) begin
					pend_d[NUM_IRQ] = 1'b1;
				end
				for (int i = 0; i < NUM_IRQ; i++) begin
					if (exc_q == EXC_IRQ_BASE + 9'(i)) begin
						pend_d[i] = 1'b1;
					end
				end
			end
			CMD_CHECK: begin
				if (check_go && tick_take) begin
					pend_d[NUM_IRQ] = 1'b0;
					taken_d         = 1'b1;
					tnum_d          = EXC_TICK;
					act_d           = EXC_TICK;
				end else if (check_go && irq_take) begin
					for (int i = 0; i < NUM_IRQ; i++) begin
						if (best_idx == IDX_W'(i)) begin
							pend_d[i] = 1'b0;
						end
					end
					taken_d = 1'b1;
					tnum_d  = EXC_IRQ_BASE + 9'(best_idx);
					act_d   = EXC_IRQ_BASE + 9'(best_idx);
				end
			end
			CMD_HARD_FAULT: begin
				if (!lock_q) begin
					if (act_q == EXC_HARD_FAULT) begin
						lock_d = 1'b1;
					end else begin
						act_d   = EXC_HARD_FAULT;
						taken_d = 1'b1;
						tnum_d  = EXC_HARD_FAULT;
					end
				end
			end
			CMD_EXC_RETURN: begin
				if (!lock_q) begin
					act_d = exc_q;
				end
			end
			default: begin
				pend_d = pend_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			act_q  <= EXC_NONE;
			lock_q <= 1'b0;
			done_q <= 1'b0;
			for (int i = 0; i < NUM_IRQ; i++) begin
				prio_q[i] <= '0;
			end
		end else begin
			done_q <= dp_ctrl.commit;
			if (dp_ctrl.commit) begin
				pend_q <= pend_d;
				act_q  <= act_d;
				lock_q <= lock_d;
				for (int i = 0; i < NUM_IRQ; i++) begin
					if (cmd_q == CMD_WR_PRIO && {2'b0, idx_q} == 6'(i)) begin
						prio_q[i] <= pb_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_ctrl.commit) begin
			taken_q <= taken_d;
			tnum_q  <= tnum_d;
		end
	end

	assign done          = done_q;
	assign taken         = taken_q;
	assign taken_number  = tnum_q;
	assign locked_up     = lock_q;
	assign active_number = act_q;

endmodule

>>> hdl/interrupt_priority_preemption_arbiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interrupt_priority_preemption_arbiter_top
// Interrupt arbiter: pending/priority state, preemption check, hard fault and
// lockup handling, with an APB configuration port.
// ----------------------------------------------------------------------------
// A command is taken at a clock edge where start is high and busy is low. Its
// result appears on the result ports for one cycle with done high, once the
// tree and decide steps have run and the result is registered; done cannot be
// held off, so capture it then. Busy is high for one cycle after each accept,
// while the first level of the priority tree (groups of four lines) is
// registered; the second level and the preemption decision complete in the
// following cycle, during which the next command may already be started.
// Configuration registers may be written only while no command is in
// flight.
module interrupt_priority_preemption_arbiter_top
	import ippa_pkg::*;
#(
	parameter int NUM_IRQ = NUM_IRQ_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  cmd,
	input  logic [8:0]  exc_number,
	input  logic [3:0]  irq_index,
	input  logic [7:0]  priority_byte,
	input  logic        interrupts_masked,
	output logic        done,
	output logic        taken,
	output logic [8:0]  taken_number,
	output logic        locked_up,
	output logic [8:0]  active_number,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t     cfg;
	dp_ctrl_t dp_ctrl;

	ippa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ippa_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.dp_ctrl (dp_ctrl)
	);

	ippa_dp #(
		.NUM_IRQ (NUM_IRQ)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.dp_ctrl           (dp_ctrl),
		.cfg               (cfg),
		.cmd               (cmd),
		.exc_number        (exc_number),
		.irq_index         (irq_index),
		.priority_byte     (priority_byte),
		.interrupts_masked (interrupts_masked),
		.done              (done),
		.taken             (taken),
		.taken_number      (taken_number),
		.locked_up         (locked_up),
		.active_number     (active_number)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	// strobe is on the ports in the cycle after commit
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result strobe missing three edges after accept");

	a_lock_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		locked_up |=> locked_up)
		else $error("lockup cleared");

	a_taken_active: assert property (@(posedge clk) disable iff (!arst_n)
		done && taken |-> active_number == taken_number)
		else $error("taken exception is not active");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the interrupt priority and preemption arbiter. A
// directed table covers reset state, the tick source, tie and strict-priority
// preemption, ignored exception numbers, unknown commands and lockup. Random
// phases follow, each under a different register setting. Every result is
// checked field by field against a typed row or a behavioral predictor.
// ----------------------------------------------------------------------------
module testbench;
	import ippa_pkg::*;

	localparam int NUM_LINES   = NUM_IRQ_DEF;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 250;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_FIRST  = 23;

	localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
	localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

	typedef struct packed {
		logic [2:0] cmd;
		logic [8:0] exc;
		logic [3:0] idx;
		logic [7:0] pb;
		logic       masked;
	} arb_cmd_t;

	typedef struct packed {
		logic       taken;
		logic [8:0] num;
		logic       lock;
		logic [8:0] active;
	} arb_result_t;

	typedef struct packed {
		arb_cmd_t    c;
		logic        typed;
		arb_result_t r;
	} stim_row_t;

	localparam arb_result_t NO_RESULT = '0;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  cmd;
	logic [8:0]  exc_number;
	logic [3:0]  irq_index;
	logic [7:0]  priority_byte;
	logic        interrupts_masked;
	logic        done;
	logic        taken;
	logic [8:0]  taken_number;
	logic        locked_up;
	logic [8:0]  active_number;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	interrupt_priority_preemption_arbiter_top u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.cmd              (cmd),
		.exc_number       (exc_number),
		.irq_index        (irq_index),
		.priority_byte    (priority_byte),
		.interrupts_masked(interrupts_masked),
		.done             (done),
		.taken            (taken),
		.taken_number     (taken_number),
		.locked_up        (locked_up),
		.active_number    (active_number),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	// predictor state and register copies
	logic [NUM_LINES:0] pending;
	logic [7:0]         line_prio_byte [NUM_LINES];
	logic [8:0]         active_exc;
	logic               lockup;
	logic [15:0]        irq_en;
	logic [31:0]        sys_prio_a;
	logic [31:0]        sys_prio_b;
	logic               reduced;

	arb_result_t outcome_q [$];
	stim_row_t   stim_table [$];
	arb_result_t seen_exp;
	int          errors;
	int          cycles;
	int          items_done;
	int          entries_taken;
	int          reg_writes;
	bit          idle_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [8:0] eff_prio(input logic [7:0] b);
		return reduced ? {7'b0, b[7:6]} : {1'b0, b};
	endfunction

	function automatic logic [8:0] line_prio(input int n);
		if (n >= NUM_LINES) return 9'd255;
		return eff_prio(line_prio_byte[n]);
	endfunction

	function automatic logic [8:0] sys_prio(input logic [8:0] e);
		logic [7:0] b;
		int         k;
		b = 8'd0;
		k = int'(e);
		if (k >= 8 && k <= 11) b = sys_prio_a[8*(k-8) +: 8];
		else if (k >= 12 && k <= 15) b = sys_prio_b[8*(k-12) +: 8];
		return eff_prio(b);
	endfunction

	function automatic logic [8:0] active_level();
		if (active_exc == EXC_NONE) return PRIO_NONE;
		if (active_exc < EXC_IRQ_BASE) return sys_prio(active_exc);
		return line_prio(int'(active_exc) - int'(EXC_IRQ_BASE));
	endfunction

	// advance the predictor by one command and return its result
	task automatic arbitrate(input arb_cmd_t c, output arb_result_t r);
		logic [8:0] ap;
		logic [8:0] best;
		int         bi;
		bit         found;
		r = '0;
		case (c.cmd)
			CMD_SET_PEND: begin
				if (c.exc >= EXC_IRQ_BASE && int'(c.exc) < int'(EXC_IRQ_BASE) + NUM_LINES)
					pending[int'(c.exc) - int'(EXC_IRQ_BASE)] = 1'b1;
				else if (c.exc == EXC_TICK)
					pending[NUM_LINES] = 1'b1;
			end
			CMD_CHECK: begin
				if (!c.masked && !lockup) begin
					ap = active_level();
					if (pending[NUM_LINES] &&
					    (active_exc == EXC_NONE || sys_prio(EXC_TICK) < ap)) begin
						pending[NUM_LINES] = 1'b0;
						r.taken = 1'b1;
						r.num = EXC_TICK;
					end else begin
						// tick blocked or absent: scan the enabled lines
						best = PRIO_NONE;
						bi = 0;
						found = 1'b0;
						for (int i = 0; i < NUM_LINES; i++) begin
							if (pending[i] && irq_en[i] && line_prio(i) < best) begin
								best = line_prio(i);
								bi = i;
								found = 1'b1;
							end
						end
						if (found && (active_exc == EXC_NONE || best < ap)) begin
							pending[bi] = 1'b0;
							r.taken = 1'b1;
							r.num = EXC_IRQ_BASE + 9'(bi);
						end
					end
					if (r.taken) active_exc = r.num;
				end
			end
			CMD_WR_PRIO: begin
				if (int'(c.idx) < NUM_LINES) line_prio_byte[c.idx] = c.pb;
			end
			CMD_HARD_FAULT: begin
				if (!lockup) begin
					if (active_exc == EXC_HARD_FAULT) begin
						lockup = 1'b1;
					end else begin
						active_exc = EXC_HARD_FAULT;
						r.taken = 1'b1;
						r.num = EXC_HARD_FAULT;
					end
				end
			end
			CMD_EXC_RETURN: begin
				if (!lockup) active_exc = c.exc;
			end
			default: begin
			end
		endcase
		r.lock = lockup;
		r.active = active_exc;
	endtask

	// hold one command on the ports until it is accepted
	task automatic issue(input arb_cmd_t c, input logic typed, input arb_result_t r);
		arb_result_t pred;
		if (idle_on && $urandom_range(99) < 24) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c.cmd;
		exc_number <= c.exc;
		irq_index <= c.idx;
		priority_byte <= c.pb;
		interrupts_masked <= c.masked;
		do @(posedge clk); while (busy);
		arbitrate(c, pred);
		outcome_q.push_back(typed ? r : pred);
		items_done++;
		if (pred.taken) entries_taken++;
	endtask

	// leaves psel high after the access edge; configure closes the burst
	task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (index)
			REG_IRQ_ENABLE: irq_en = value[15:0];
			REG_SYS_PRIO_A: sys_prio_a = value;
			REG_SYS_PRIO_B: sys_prio_b = value;
			REG_REDUCED:    reduced = value[0];
			default: begin
			end
		endcase
		reg_writes++;
	endtask

	task automatic configure(input logic [15:0] en, input logic [31:0] a,
	                         input logic [31:0] b, input logic red);
		write_reg(REG_IRQ_ENABLE, {16'h0, en});
		write_reg(REG_SYS_PRIO_A, a);
		write_reg(REG_SYS_PRIO_B, b);
		write_reg(REG_REDUCED, {31'h0, red});
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop issuing and let every outstanding transaction come back
	task automatic drain();
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_rows(input int first, input int last);
		for (int i = first; i <= last; i++)
			issue(stim_table[i].c, stim_table[i].typed, stim_table[i].r);
	endtask

	task automatic add_row(input arb_cmd_t c, input logic typed, input arb_result_t r);
		stim_row_t row;
		row.c = c;
		row.typed = typed;
		row.r = r;
		stim_table.push_back(row);
	endtask

	function automatic arb_cmd_t rand_cmd();
		arb_cmd_t c;
		int       sel;
		int       pick;
		c.cmd = CMD_CHECK;
		c.exc = 9'($urandom_range(511));
		c.idx = 4'($urandom_range(15));
		c.pb = 8'($urandom_range(255));
		c.masked = ($urandom_range(99) < 15);
		sel = $urandom_range(99);
		pick = $urandom_range(9);
		if (sel < 30) begin
			c.cmd = CMD_SET_PEND;
			if (pick == 1) c.exc = EXC_TICK;
			else if (pick != 0) c.exc = EXC_IRQ_BASE + 9'($urandom_range(NUM_LINES - 1));
		end else if (sel < 65) begin
			c.cmd = CMD_CHECK;
		end else if (sel < 80) begin
			c.cmd = CMD_WR_PRIO;
			if (pick < 3) c.pb = pick[0] ? 8'hFF : 8'h00;
		end else if (sel < 85) begin
			c.cmd = CMD_HARD_FAULT;
			// a second hard fault would lock the block for the rest of the run
			if (active_exc == EXC_HARD_FAULT) begin
				c.cmd = CMD_EXC_RETURN;
				c.exc = EXC_NONE;
			end
		end else if (sel < 97) begin
			c.cmd = CMD_EXC_RETURN;
			if (pick < 4) c.exc = EXC_NONE;
			else if (pick < 6) c.exc = 9'($urandom_range(15, 8));
			else if (pick < 9) c.exc = EXC_IRQ_BASE + 9'($urandom_range(NUM_LINES - 1));
		end else begin
			c.cmd = 3'($urandom_range(7, 5));
		end
		return c;
	endfunction

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				seen_exp = outcome_q.pop_front();
				if (taken !== seen_exp.taken) begin
					$error("taken: expected %0d, actual %0d", seen_exp.taken, taken);
					errors++;
				end
				if (taken_number !== seen_exp.num) begin
					$error("taken_number: expected %0d, actual %0d",
					       seen_exp.num, taken_number);
					errors++;
				end
				if (locked_up !== seen_exp.lock) begin
					$error("locked_up: expected %0d, actual %0d", seen_exp.lock, locked_up);
					errors++;
				end
				if (active_number !== seen_exp.active) begin
					$error("active_number: expected %0d, actual %0d",
					       seen_exp.active, active_number);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		items_done = 0;
		entries_taken = 0;
		reg_writes = 0;
		idle_on = 1'b1;
		pending = '0;
		for (int i = 0; i < NUM_LINES; i++) line_prio_byte[i] = 8'd0;
		active_exc = EXC_NONE;
		lockup = 1'b0;
		irq_en = '0;
		sys_prio_a = '0;
		sys_prio_b = '0;
		reduced = 1'b0;

		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= CMD_SET_PEND;
		exc_number <= '0;
		irq_index <= '0;
		priority_byte <= '0;
		interrupts_masked <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;

		// opening rows: tick, masking, ties, ignored numbers, out-of-range active
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1, {1'b0, 9'd0, 1'b0, 9'd0});
		add_row({CMD_SET_PEND, EXC_TICK, 4'd0, 8'd0, 1'b0}, 1'b1, {1'b0, 9'd0, 1'b0, 9'd0});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b1}, 1'b1, {1'b0, 9'd0, 1'b0, 9'd0});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1, {1'b1, EXC_TICK, 1'b0, EXC_TICK});
		add_row({CMD_SET_PEND, 9'd16, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b0, EXC_TICK});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_EXC_RETURN, EXC_NONE, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b0, 9'd0});
		add_row({CMD_WR_PRIO, 9'd0, 4'd15, 8'd255, 1'b0}, 1'b1, {1'b0, 9'd0, 1'b0, 9'd0});
		add_row({CMD_WR_PRIO, 9'd0, 4'd0, 8'd200, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_SET_PEND, 9'd31, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_SET_PEND, 9'd32, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_SET_PEND, 9'd511, 4'd15, 8'd255, 1'b1}, 1'b0, NO_RESULT);
		add_row({CMD_SET_PEND, 9'd14, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1, {1'b1, 9'd16, 1'b0, 9'd16});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_EXC_RETURN, 9'd400, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b0, 9'd400});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_WR_PRIO, 9'd0, 4'd15, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_UNUSED_5, 9'd15, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_UNUSED_7, 9'd0, 4'd3, 8'd9, 1'b1}, 1'b0, NO_RESULT);
		add_row({CMD_HARD_FAULT, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b1, EXC_HARD_FAULT, 1'b0, EXC_HARD_FAULT});
		add_row({CMD_EXC_RETURN, EXC_NONE, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b0, 9'd0});
		// closing rows: lockup is permanent, so it comes last
		add_row({CMD_EXC_RETURN, EXC_NONE, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b0, 9'd0});
		add_row({CMD_HARD_FAULT, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b1, EXC_HARD_FAULT, 1'b0, EXC_HARD_FAULT});
		add_row({CMD_HARD_FAULT, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b1, EXC_HARD_FAULT});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_SET_PEND, EXC_TICK, 4'd0, 8'd0, 1'b0}, 1'b0, NO_RESULT);
		add_row({CMD_HARD_FAULT, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b1, EXC_HARD_FAULT});
		add_row({CMD_EXC_RETURN, EXC_NONE, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b1, EXC_HARD_FAULT});
		add_row({CMD_CHECK, 9'd0, 4'd0, 8'd0, 1'b0}, 1'b1,
		        {1'b0, 9'd0, 1'b1, EXC_HARD_FAULT});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		configure(16'hFFFF, 32'h0, 32'h0, 1'b0);
		run_rows(0, TAIL_FIRST - 1);
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
				1: configure(16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
				default: configure(16'($urandom), $urandom, $urandom, ph[0]);
			endcase
			// one phase runs back to back with no gaps at all
			idle_on = (ph != 2);
			for (int n = 0; n < PHASE_ITEMS; n++) issue(rand_cmd(), 1'b0, NO_RESULT);
			drain();
		end

		idle_on = 1'b1;
		run_rows(TAIL_FIRST, stim_table.size() - 1);
		start <= 1'b0;
		while (outcome_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("ran %0d commands over %0d register settings, %0d register writes",
		         items_done, PHASES + 1, reg_writes);
		$display("%0d exceptions entered, lockup reached: %0d", entries_taken, lockup);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
